// ===== hdl/assert_macros.svh =====
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== hdl/rls_pkg.sv =====
package rls_pkg;

  localparam int ACTION_W      = 2;
  localparam int POS_W         = 11;
  localparam int VALUE_W       = 32;
  localparam int STEP_W        = 16;
  localparam int INDEX_W       = 10;
  localparam int COUNT_W       = 11;
  localparam int DEPTH_DEFAULT = 1024;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ROTATE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

  localparam logic DIR_LEFT = 1'b0;

  typedef struct packed {
    logic capture;
    logic decide;
    logic div_start;
    logic div_step;
    logic rotate;
    logic rd_issue;
    logic rd_latch;
    logic copy_start;
    logic copy_step;
    logic commit;
    logic load_result;
  } rls_cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                ins_ok;
    logic                rd_ok;
    logic                count_zero;
    logic                div_done;
    logic                copy_done;
  } rls_stat_t;

endpackage

// ===== hdl/rls_in_if.sv =====
interface rls_in_if;
  logic                                     valid;
  logic                                     ready;
  logic        [rls_pkg::ACTION_W-1:0]      action;
  logic        [rls_pkg::POS_W-1:0]         position;
  logic signed [rls_pkg::VALUE_W-1:0]       value;
  logic                                     direction;
  logic        [rls_pkg::STEP_W-1:0]        step;
  logic        [rls_pkg::INDEX_W-1:0]       index;

  modport source (
    output valid, action, position, value, direction, step, index,
    input  ready
  );
  modport sink (
    input  valid, action, position, value, direction, step, index,
    output ready
  );
endinterface

// ===== hdl/rls_out_if.sv =====
interface rls_out_if;
  logic                                valid;
  logic                                ready;
  logic                                status;
  logic signed [rls_pkg::VALUE_W-1:0]  read_value;
  logic        [rls_pkg::COUNT_W-1:0]  count;

  modport source (
    output valid, status, read_value, count,
    input  ready
  );
  modport sink (
    input  valid, status, read_value, count,
    output ready
  );
endinterface

// ===== hdl/rls_datapath.sv =====
module rls_datapath #(
  parameter int DEPTH = rls_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rls_pkg::rls_cmd_t                   cmd,
  output rls_pkg::rls_stat_t                  stat,
  input  logic        [rls_pkg::ACTION_W-1:0] in_action,
  input  logic        [rls_pkg::POS_W-1:0]    in_position,
  input  logic signed [rls_pkg::VALUE_W-1:0]  in_value,
  input  logic                                in_direction,
  input  logic        [rls_pkg::STEP_W-1:0]   in_step,
  input  logic        [rls_pkg::INDEX_W-1:0]  in_index,
  output logic                                out_status,
  output logic signed [rls_pkg::VALUE_W-1:0]  out_read_value,
  output logic        [rls_pkg::COUNT_W-1:0]  out_count
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CW1   = CW + 1;
  localparam int CMPW  = ((CW > rls_pkg::POS_W) ? CW : rls_pkg::POS_W) + 1;
  localparam int VW    = rls_pkg::VALUE_W;
  localparam int SW    = rls_pkg::STEP_W;
  localparam int DCW   = $clog2(SW + 1);
  localparam int CNTW  = rls_pkg::COUNT_W;

  // captured item
  logic        [rls_pkg::ACTION_W-1:0] act_q;
  logic        [rls_pkg::POS_W-1:0]    pos_q;
  logic signed [VW-1:0]                val_q;
  logic                                dir_q;
  logic        [SW-1:0]                step_q;
  logic        [rls_pkg::INDEX_W-1:0]  idx_q;

  // list state
  logic [CW-1:0] count;
  logic [AW-1:0] origin;
  logic          bank;
  logic          err_q;
  logic          err_next;
  logic [VW-1:0] rval_q;

  // two banks; a copy pass rebuilds the list in logical order into the idle one
  logic [VW-1:0] mem0 [DEPTH];
  logic [VW-1:0] mem1 [DEPTH];
  logic [VW-1:0] rdata0;
  logic [VW-1:0] rdata1;
  logic [VW-1:0] rdata;
  logic [AW-1:0] rd_addr;
  logic          rd_en;

  // remainder unit for step mod count
  logic [CW-1:0]  rem;
  logic [CW1-1:0] rem_shift;
  logic [SW-1:0]  dsh;
  logic [DCW-1:0] dcnt;

  // copy pass
  logic [CW-1:0] j;
  logic [AW-1:0] src;
  logic [AW-1:0] src_inc;
  logic          issue_active;
  logic          is_ins_slot;
  logic          w_valid;
  logic          w_use_val;
  logic [AW-1:0] w_idx;
  logic [VW-1:0] wdata;

  logic [CW1-1:0]  rot_sum;
  logic [CW1-1:0]  rot_wrap;
  logic [CMPW-1:0] phys_sum;
  logic [CMPW-1:0] phys_wrap;

  always_comb begin
    stat.action     = act_q;
    stat.ins_ok     = (CMPW'(count) < CMPW'(DEPTH)) && (pos_q != '0) &&
                      (CMPW'(pos_q) <= CMPW'(count) + CMPW'(1));
    stat.rd_ok      = CMPW'(idx_q) < CMPW'(count);
    stat.count_zero = (count == '0);
    stat.div_done   = (dcnt == DCW'(SW));
    stat.copy_done  = !issue_active && !w_valid;
  end

  always_comb begin
    unique case (act_q)
      rls_pkg::ACT_INSERT: err_next = !stat.ins_ok;
      rls_pkg::ACT_ROTATE: err_next = 1'b0;
      rls_pkg::ACT_READ:   err_next = !stat.rd_ok;
      default:             err_next = 1'b1;
    endcase
  end

  // logical index to stored slot
  always_comb begin
    phys_sum  = CMPW'(origin) + CMPW'(idx_q);
    phys_wrap = (phys_sum >= CMPW'(count)) ? phys_sum - CMPW'(count) : phys_sum;
  end

  always_comb begin
    rem_shift = {rem, dsh[SW-1]};
    if (dir_q == rls_pkg::DIR_LEFT) begin
      rot_sum = CW1'(origin) + CW1'(rem);
    end else begin
      rot_sum = CW1'(origin) + CW1'(count) - CW1'(rem);
    end
    rot_wrap = (rot_sum >= CW1'(count)) ? rot_sum - CW1'(count) : rot_sum;
  end

  always_comb begin
    issue_active = (j <= count);
    is_ins_slot  = (CMPW'(j) + CMPW'(1) == CMPW'(pos_q));
    src_inc      = (CW'(src) + CW'(1) == count) ? '0 : src + AW'(1);
    rd_addr      = cmd.rd_issue ? phys_wrap[AW-1:0] : src;
    rd_en        = cmd.rd_issue || (cmd.copy_step && issue_active && !is_ins_slot);
    rdata        = bank ? rdata1 : rdata0;
    wdata        = w_use_val ? val_q : rdata;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata0 <= mem0[rd_addr];
      rdata1 <= mem1[rd_addr];
    end
    if (w_valid && bank) begin
      mem0[w_idx] <= wdata;
    end
    if (w_valid && !bank) begin
      mem1[w_idx] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q  <= in_action;
      pos_q  <= in_position;
      val_q  <= in_value;
      dir_q  <= in_direction;
      step_q <= in_step;
      idx_q  <= in_index;
    end
    if (cmd.decide) begin
      err_q <= err_next;
    end
    if (cmd.div_start) begin
      rem  <= '0;
      dsh  <= step_q;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      rem  <= (rem_shift >= CW1'(count)) ? CW'(rem_shift - CW1'(count)) : CW'(rem_shift);
      dsh  <= {dsh[SW-2:0], 1'b0};
      dcnt <= dcnt + DCW'(1);
    end
    if (cmd.rd_latch) begin
      rval_q <= rdata;
    end
    if (cmd.copy_start) begin
      j   <= '0;
      src <= origin;
    end else if (cmd.copy_step && issue_active) begin
      j <= j + CW'(1);
      if (!is_ins_slot) begin
        src <= src_inc;
      end
    end
    w_idx     <= j[AW-1:0];
    w_use_val <= is_ins_slot;
    if (cmd.load_result) begin
      out_status     <= err_q;
      out_read_value <= (act_q == rls_pkg::ACT_READ && !err_q) ? rval_q : '0;
      out_count      <= CNTW'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      origin  <= '0;
      bank    <= 1'b0;
      w_valid <= 1'b0;
    end else begin
      w_valid <= cmd.copy_step && issue_active;
      if (cmd.rotate) begin
        origin <= rot_wrap[AW-1:0];
      end else if (cmd.commit) begin
        origin <= '0;
        bank   <= ~bank;
        count  <= count + CW'(1);
      end
    end
  end

endmodule

// ===== hdl/rls_ctrl.sv =====
module rls_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  rls_pkg::rls_stat_t stat,
  output rls_pkg::rls_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_DIV     = 3'd2;
  localparam logic [2:0] S_RD_DATA = 3'd3;
  localparam logic [2:0] S_COPY    = 3'd4;
  localparam logic [2:0] S_FINISH  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decide = 1'b1;
        state_next = S_FINISH;
        unique case (stat.action)
          rls_pkg::ACT_INSERT: begin
            if (stat.ins_ok) begin
              cmd.copy_start = 1'b1;
              state_next     = S_COPY;
            end
          end
          rls_pkg::ACT_ROTATE: begin
            if (!stat.count_zero) begin
              cmd.div_start = 1'b1;
              state_next    = S_DIV;
            end
          end
          rls_pkg::ACT_READ: begin
            if (stat.rd_ok) begin
              cmd.rd_issue = 1'b1;
              state_next   = S_RD_DATA;
            end
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.rotate = 1'b1;
          state_next = S_FINISH;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_RD_DATA: begin
        cmd.rd_latch = 1'b1;
        state_next   = S_FINISH;
      end
      S_COPY: begin
        if (stat.copy_done) begin
          cmd.commit = 1'b1;
          state_next = S_FINISH;
        end else begin
          cmd.copy_step = 1'b1;
        end
      end
      S_FINISH: begin
        // wait here while the previous beat is still held
        if (!out_valid || out_ready) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/rotatable_list_store.sv =====
// Ordered list of up to DEPTH signed 32-bit words with insert, rotate and read.
// Channels: item (sink) carries one action per beat; result (source) returns
// exactly one beat per item with status, read_value and the count after it.
// Both use valid/ready; a beat moves when both are high on a rising edge.
// Steps from accept to result valid, by action:
//   read    decode, then one memory read
//   rotate  16-step remainder unit computes step mod count, then the rotation
//   insert  one memory access per entry while the list is copied, in logical
//           order, into the second bank
//   errors, unknown actions and rotate of an empty list go straight to finish
// One item is worked on at a time; the next one is taken once the current one
// has reached the output register.
// A finished result waits in the output register while result.ready is low;
// the following item is still accepted and is worked on until its own result
// is ready, then the block holds until the output register frees up.
// Reset (rst, synchronous) empties the list and clears the rotation; stored
// words are not cleared and are only read after they were written.
module rotatable_list_store #(
  parameter int DEPTH = rls_pkg::DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  rls_in_if.sink    item,
  rls_out_if.source result
);

  rls_pkg::rls_cmd_t  cmd;
  rls_pkg::rls_stat_t stat;

  rls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rls_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .in_action      (item.action),
    .in_position    (item.position),
    .in_value       (item.value),
    .in_direction   (item.direction),
    .in_step        (item.step),
    .in_index       (item.index),
    .out_status     (result.status),
    .out_read_value (result.read_value),
    .out_count      (result.count)
  );

endmodule

// ===== hdl/rls_checker.sv =====
`include "assert_macros.svh"

module rls_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               item_valid,
  input logic                               item_ready,
  input logic                               result_valid,
  input logic                               result_ready,
  input logic                               result_status,
  input logic [rls_pkg::VALUE_W-1:0]        result_read_value,
  input logic [rls_pkg::COUNT_W-1:0]        result_count
);

  localparam int CNTW = rls_pkg::COUNT_W;

  logic [1:0]      pending;
  logic [CNTW-1:0] last_cnt;
  logic [CNTW-1:0] last_cnt_inc;
  logic            in_beat;
  logic            out_beat;

  assign in_beat      = item_valid && item_ready;
  assign out_beat     = result_valid && result_ready;
  assign last_cnt_inc = last_cnt + CNTW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending  <= '0;
      last_cnt <= '0;
    end else begin
      pending <= pending + {1'b0, in_beat} - {1'b0, out_beat};
      if (out_beat) begin
        last_cnt <= result_count;
      end
    end
  end

  `ASSERT_NEXT(a_rst_quiet, clk, 1'b0, rst, !result_valid)
  `ASSERT_NEXT(a_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(result_count) && $stable(result_read_value) && $stable(result_status))
  `ASSERT_SAME(a_err_zero, clk, rst, result_valid && result_status, result_read_value == '0)
  `ASSERT_SAME(a_count_step, clk, rst, result_valid, result_count == last_cnt || result_count == last_cnt_inc)
  `ASSERT_SAME(a_no_orphan, clk, rst, result_valid, pending != 2'd0)

endmodule

bind rotatable_list_store rls_checker u_rls_checker (
  .clk               (clk),
  .rst               (rst),
  .item_valid        (item.valid),
  .item_ready        (item.ready),
  .result_valid      (result.valid),
  .result_ready      (result.ready),
  .result_status     (result.status),
  .result_read_value (result.read_value),
  .result_count      (result.count)
);

// ===== tb/sv/rotatable_list_store_tb.sv =====
module rotatable_list_store_tb;

  localparam int DEPTH = rls_pkg::DEPTH_DEFAULT;
  localparam int STALL_LIMIT = 20000;
  localparam int LONG_HOLD = 300;
  localparam int RANDOM_ITEMS = 330;

  typedef logic        [rls_pkg::ACTION_W-1:0] action_t;
  typedef logic        [rls_pkg::POS_W-1:0]    pos_t;
  typedef logic signed [rls_pkg::VALUE_W-1:0]  word_t;
  typedef logic        [rls_pkg::STEP_W-1:0]   step_t;
  typedef logic        [rls_pkg::INDEX_W-1:0]  index_t;
  typedef logic        [rls_pkg::COUNT_W-1:0]  count_t;

  localparam action_t ACT_UNKNOWN = 2'd3;
  localparam logic DIR_RIGHT = 1'b1;
  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct {
    action_t action;
    pos_t    position;
    word_t   value;
    logic    direction;
    step_t   step;
    index_t  index;
  } list_item_t;

  typedef struct {
    logic   status;
    word_t  read_value;
    count_t count;
  } list_result_t;

  class list_scoreboard;
    word_t list_words[$];  // logical order, element 0 first
    list_result_t due_results[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function void note_item(list_item_t it);
      list_result_t r;
      int unsigned n;
      int unsigned s;
      n = list_words.size();
      r.status = STATUS_OK;
      r.read_value = '0;
      case (it.action)
        rls_pkg::ACT_INSERT: begin
          if (n >= DEPTH || it.position == 0 || it.position > n + 1)
            r.status = STATUS_ERR;
          else
            list_words.insert(it.position - 1, it.value);
        end
        rls_pkg::ACT_ROTATE: begin
          if (n != 0) begin
            s = it.step % n;
            repeat (s) begin
              if (it.direction == rls_pkg::DIR_LEFT)
                list_words.push_back(list_words.pop_front());
              else
                list_words.push_front(list_words.pop_back());
            end
          end
        end
        rls_pkg::ACT_READ: begin
          if (it.index >= n)
            r.status = STATUS_ERR;
          else
            r.read_value = list_words[it.index];
        end
        default: r.status = STATUS_ERR;
      endcase
      r.count = count_t'(list_words.size());
      due_results.push_back(r);
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result beat: status %0d read_value %0d count %0d",
               got.status, got.read_value, got.count);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.read_value !== want.read_value) begin
        $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
        errors++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic idle_on;
  logic hold_request;
  int   quiet_cycles;
  list_scoreboard board;

  rls_in_if  item_ch ();
  rls_out_if result_ch ();

  rotatable_list_store #(.DEPTH(DEPTH)) DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // beat monitor, prediction, checking and no-progress watchdog
  always @(posedge clk) begin
    list_item_t   it;
    list_result_t got;
    if (!rst && item_ch.valid && item_ch.ready) begin
      it.action    = item_ch.action;
      it.position  = item_ch.position;
      it.value     = item_ch.value;
      it.direction = item_ch.direction;
      it.step      = item_ch.step;
      it.index     = item_ch.index;
      board.note_item(it);
    end
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.status     = result_ch.status;
      got.read_value = result_ch.read_value;
      got.count      = result_ch.count;
      board.check_result(got);
    end
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("[rotatable_list_store] ERROR");
      $finish;
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        result_ch.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 7) == 0)
          stall_left = $urandom_range(1, 17);
      end
    end
  end

  function automatic list_item_t mk(action_t a, int p, int v, logic d, int s, int x);
    list_item_t it;
    it.action = a;
    it.position = pos_t'(p);
    it.value = word_t'(v);
    it.direction = d;
    it.step = step_t'(s);
    it.index = index_t'(x);
    return it;
  endfunction

  function automatic list_item_t random_item(int unsigned n);
    list_item_t  it;
    int unsigned pick;
    it.position = pos_t'($urandom);
    it.value = word_t'($urandom);
    it.direction = 1'($urandom_range(0, 1));
    it.step = step_t'($urandom);
    it.index = index_t'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 38) begin
      it.action = rls_pkg::ACT_INSERT;
      if ($urandom_range(0, 9) != 0)
        it.position = pos_t'($urandom_range(1, n + 1));
    end else if (pick < 60) begin
      it.action = rls_pkg::ACT_ROTATE;
      if ($urandom_range(0, 1) == 0)
        it.step = step_t'($urandom_range(0, 2 * n + 2));
    end else if (pick < 95) begin
      it.action = rls_pkg::ACT_READ;
      if (n != 0 && $urandom_range(0, 9) != 0)
        it.index = index_t'($urandom_range(0, n - 1));
    end else begin
      it.action = ACT_UNKNOWN;
    end
    return it;
  endfunction

  // called at a falling edge; returns at the falling edge after the beat
  task automatic send_item(list_item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.action    <= it.action;
    item_ch.position  <= it.position;
    item_ch.value     <= it.value;
    item_ch.direction <= it.direction;
    item_ch.step      <= it.step;
    item_ch.index     <= it.index;
    do @(posedge clk); while (!item_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    item_ch.valid <= 1'b0;
    while (board.due_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    idle_on = 1'b1;
    hold_request = 1'b0;
    quiet_cycles = 0;
    item_ch.valid = 1'b0;
    item_ch.action = rls_pkg::ACT_INSERT;
    item_ch.position = '0;
    item_ch.value = '0;
    item_ch.direction = rls_pkg::DIR_LEFT;
    item_ch.step = '0;
    item_ch.index = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty list, bad positions, value extremes, rotations, bad index, unknown action
    send_item(mk(rls_pkg::ACT_READ,   0, 0, rls_pkg::DIR_LEFT, 0, 0));
    send_item(mk(rls_pkg::ACT_ROTATE, 0, 0, rls_pkg::DIR_LEFT, 16'hFFFF, 0));
    send_item(mk(rls_pkg::ACT_INSERT, 0, 5, rls_pkg::DIR_LEFT, 0, 0));
    send_item(mk(rls_pkg::ACT_INSERT, 2, 5, rls_pkg::DIR_LEFT, 0, 0));
    send_item(mk(rls_pkg::ACT_INSERT, 1, 32'h7FFF_FFFF, rls_pkg::DIR_LEFT, 0, 0));
    send_item(mk(rls_pkg::ACT_INSERT, 1, 32'h8000_0000, rls_pkg::DIR_LEFT, 0, 0));
    send_item(mk(rls_pkg::ACT_INSERT, 3, -1, rls_pkg::DIR_LEFT, 0, 0));
    send_item(mk(rls_pkg::ACT_INSERT, 2, 0, rls_pkg::DIR_LEFT, 0, 0));
    send_item(mk(rls_pkg::ACT_INSERT, 2047, 7, DIR_RIGHT, 16'hFFFF, 10'h3FF));
    send_item(mk(rls_pkg::ACT_INSERT, DEPTH, 7, rls_pkg::DIR_LEFT, 0, 0));
    send_item(mk(rls_pkg::ACT_READ,   0, 0, rls_pkg::DIR_LEFT, 0, 3));
    send_item(mk(rls_pkg::ACT_READ,   0, 0, rls_pkg::DIR_LEFT, 0, 4));
    send_item(mk(rls_pkg::ACT_READ,   2047, -1, DIR_RIGHT, 16'hFFFF, 10'h3FF));
    send_item(mk(rls_pkg::ACT_ROTATE, 0, 0, rls_pkg::DIR_LEFT, 1, 0));
    send_item(mk(rls_pkg::ACT_READ,   0, 0, rls_pkg::DIR_LEFT, 0, 0));
    send_item(mk(rls_pkg::ACT_ROTATE, 0, 0, DIR_RIGHT, 16'hFFFF, 0));
    send_item(mk(rls_pkg::ACT_READ,   0, 0, rls_pkg::DIR_LEFT, 0, 0));
    send_item(mk(rls_pkg::ACT_ROTATE, 0, 0, DIR_RIGHT, 0, 0));
    send_item(mk(rls_pkg::ACT_ROTATE, 0, 0, rls_pkg::DIR_LEFT, 8, 0));
    send_item(mk(ACT_UNKNOWN,         1, 9, rls_pkg::DIR_LEFT, 1, 0));
    send_item(mk(rls_pkg::ACT_ROTATE, 0, 0, rls_pkg::DIR_LEFT, 3, 0));
    // insert into a rotated list
    send_item(mk(rls_pkg::ACT_INSERT, 3, 12345, rls_pkg::DIR_LEFT, 0, 0));
    send_item(mk(rls_pkg::ACT_READ,   0, 0, rls_pkg::DIR_LEFT, 0, 2));
    send_item(mk(rls_pkg::ACT_READ,   0, 0, rls_pkg::DIR_LEFT, 0, 4));

    // back-pressure: hold the result side while items keep coming
    hold_request = 1'b1;
    repeat (8) send_item(random_item(board.list_words.size()));
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0)
        idle_on = ($urandom_range(0, 3) != 0);
      send_item(random_item(board.list_words.size()));
      if (i == RANDOM_ITEMS / 2)
        drain_results();
    end

    // last part: no idling; list ends, far positions and indexes
    idle_on = 1'b0;
    send_item(mk(rls_pkg::ACT_INSERT, DEPTH + 1, 11, rls_pkg::DIR_LEFT, 0, 0));
    send_item(mk(rls_pkg::ACT_INSERT, board.list_words.size() + 1, 11,
                 rls_pkg::DIR_LEFT, 0, 0));
    send_item(mk(rls_pkg::ACT_READ,   0, 0, rls_pkg::DIR_LEFT, 0, DEPTH - 1));
    send_item(mk(rls_pkg::ACT_ROTATE, 0, 0, DIR_RIGHT, 16'hFFFF, 0));
    send_item(mk(rls_pkg::ACT_READ,   0, 0, rls_pkg::DIR_LEFT, 0, 0));
    send_item(mk(rls_pkg::ACT_READ,   0, 0, rls_pkg::DIR_LEFT, 0,
                 board.list_words.size() - 1));
    send_item(mk(rls_pkg::ACT_ROTATE, 0, 0, rls_pkg::DIR_LEFT, DEPTH, 0));
    send_item(mk(rls_pkg::ACT_READ,   0, 0, rls_pkg::DIR_LEFT, 0, 517));
    send_item(mk(ACT_UNKNOWN,         0, 0, rls_pkg::DIR_LEFT, 0, 0));
    for (int i = 0; i < 20; i++)
      send_item(random_item(board.list_words.size()));
    drain_results();

    repeat (40) @(posedge clk);
    if (board.errors == 0 && board.due_results.size() == 0)
      $display("[rotatable_list_store] OK");
    else
      $display("[rotatable_list_store] ERROR");
    $finish;
  end

endmodule
